FILE: sv/vpsf_pkg.sv
// ----------------------------------------------------------------------------
// Voxel phantom shape fill package
// Shared widths, register indexes, shape codes and a width helper.
// ----------------------------------------------------------------------------
package vpsf_pkg;

    localparam int IDX_W      = 8;
    localparam int CENTER_W   = 18;
    localparam int HALF_W     = 16;
    localparam int DENS_W     = 16;
    localparam int ADDR_W     = 24;
    localparam int KIND_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam int GRID_W     = 11;
    localparam int WIN_W      = CENTER_W + 1;

    typedef enum logic [KIND_W-1:0] {
        SHAPE_SPHERE = 3'd0,
        SHAPE_BOX    = 3'd1,
        SHAPE_CYL_X  = 3'd2,
        SHAPE_CYL_Y  = 3'd3,
        SHAPE_CYL_Z  = 3'd4
    } t_shape_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SHAPE_KIND = 3'd0,
        CFG_CENTER_X   = 3'd1,
        CFG_CENTER_Y   = 3'd2,
        CFG_CENTER_Z   = 3'd3,
        CFG_HALF_X     = 3'd4,
        CFG_HALF_Y     = 3'd5,
        CFG_HALF_Z     = 3'd6,
        CFG_DENSITY    = 3'd7
    } t_cfg_reg;

    // Width of the magnitude of a voxel offset from the shape center.
    function automatic int mag_width(input int frac_bits);
        int scaled_w;
        begin
            scaled_w = IDX_W + frac_bits + 1;
            return (scaled_w > CENTER_W) ? scaled_w : CENTER_W;
        end
    endfunction

endpackage

FILE: sv/vpsf_axis.sv
// ----------------------------------------------------------------------------
// Voxel phantom axis unit
// Offset magnitude of one voxel index from the center and bounding window test.
// ----------------------------------------------------------------------------
module vpsf_axis #(
    parameter int FRACTION_BITS = 8,
    parameter int GRID          = 256
) (
    input  logic [vpsf_pkg::IDX_W-1:0]           i_idx,
    input  logic signed [vpsf_pkg::CENTER_W-1:0] i_center,
    input  logic [vpsf_pkg::HALF_W-1:0]          i_half,
    output logic [vpsf_pkg::mag_width(FRACTION_BITS)-1:0] o_mag,
    output logic                                 o_in_window
);
    import vpsf_pkg::*;

    localparam int MW = mag_width(FRACTION_BITS);
    localparam int DW = MW + 1;

    logic signed [DW-1:0]    diff;
    logic signed [DW-1:0]    neg_diff;
    logic signed [WIN_W-1:0] c_ext;
    logic signed [WIN_W-1:0] h_ext;
    logic signed [WIN_W-1:0] lo;
    logic signed [WIN_W-1:0] hi;
    logic signed [WIN_W-1:0] idx_ext;

    assign diff     = $signed(DW'(i_idx) << FRACTION_BITS) - DW'(i_center);
    assign neg_diff = -diff;
    assign o_mag    = diff[DW-1] ? neg_diff[MW-1:0] : diff[MW-1:0];

    assign c_ext   = WIN_W'(i_center);
    assign h_ext   = $signed(WIN_W'(i_half));
    assign lo      = (c_ext - h_ext) >>> FRACTION_BITS;
    assign hi      = (c_ext + h_ext) >>> FRACTION_BITS;
    assign idx_ext = $signed(WIN_W'(i_idx));

    assign o_in_window = (idx_ext >= lo) && (idx_ext < hi) &&
                         (GRID_W'(i_idx) < GRID_W'(GRID));

endmodule

FILE: sv/voxel_phantom_shape_fill.sv
// ----------------------------------------------------------------------------
// Voxel phantom shape fill
// Decides per voxel whether it lies in the configured solid and emits a write.
// ----------------------------------------------------------------------------
// Voxel coordinates arrive on the input channel (i_valid, o_ready) and one
// write transaction per voxel leaves on the output channel (o_valid, i_ready)
// with the enable, the linear address and the density. The address is always
// given; the density is zero when the enable is low.
// Shape registers are loaded through the configuration channel (i_cfg_valid,
// o_cfg_ready), which is always ready. The user must change them only while
// no voxel is in flight; the block itself does not enforce this.
// The block is a four-stage pipeline: offsets and windows, cross products,
// squares, then sum and compare into the output register, which holds a
// result until the receiver takes it. One voxel is taken every cycle while
// input ready is high.
// Each stage holds its own valid bit and loads when it is empty or its
// successor loads, so a stalled receiver freezes only the full stages and
// bubbles are squeezed out; input ready drops only when all four stages are
// full and the receiver stalls.
// Reset clears all stage valid bits and returns every shape register to zero,
// which selects a zero-radius sphere that writes nothing.
module voxel_phantom_shape_fill #(
    parameter int GRID_X        = 256,
    parameter int GRID_Y        = 256,
    parameter int GRID_Z        = 256,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vpsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vpsf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [vpsf_pkg::IDX_W-1:0]          i_voxel_x,
    input  logic [vpsf_pkg::IDX_W-1:0]          i_voxel_y,
    input  logic [vpsf_pkg::IDX_W-1:0]          i_voxel_z,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_write_enable,
    output logic [vpsf_pkg::ADDR_W-1:0]         o_voxel_address,
    output logic [vpsf_pkg::DENS_W-1:0]         o_density_out
);
    import vpsf_pkg::*;

    localparam int MW   = mag_width(FRACTION_BITS);
    localparam int UW   = MW + HALF_W;
    localparam int TW   = 2 * HALF_W;
    localparam int SUMW = 2 * UW + 2;

    logic [KIND_W-1:0]          r_shape_kind;
    logic signed [CENTER_W-1:0] r_center_x, r_center_y, r_center_z;
    logic [HALF_W-1:0]          r_half_x, r_half_y, r_half_z;
    logic [DENS_W-1:0]          r_density;

    logic ld1, ld2, ld3, ld4;
    logic r_v1, r_v2, r_v3, r_v4;

    logic [MW-1:0]     n1_mag_x, n1_mag_y, n1_mag_z;
    logic              win_x, win_y, win_z;
    logic [HALF_W-1:0] half_y_eff, half_z_eff;
    logic              n1_in;
    logic [ADDR_W-1:0] n1_zx;

    logic [MW-1:0]     r1_mag_x, r1_mag_y, r1_mag_z;
    logic              r1_in;
    logic [ADDR_W-1:0] r1_zx;
    logic [IDX_W-1:0]  r1_y;

    logic [MW-1:0]     sel_ma, sel_mb;
    logic [HALF_W-1:0] sel_ha, sel_hb;
    logic [UW-1:0]     prod_a, prod_b;
    logic [TW-1:0]     prod_h;
    logic [UW-1:0]     n2_u, n2_v;
    logic [MW-1:0]     n2_w;
    logic [TW-1:0]     n2_t;
    logic [ADDR_W-1:0] n2_addr;

    logic [UW-1:0]     r2_u, r2_v;
    logic [MW-1:0]     r2_w;
    logic [TW-1:0]     r2_t;
    logic              r2_in;
    logic [ADDR_W-1:0] r2_addr;

    logic [2*UW-1:0]   r3_su, r3_sv;
    logic [2*MW-1:0]   r3_sw;
    logic [2*TW-1:0]   r3_st;
    logic              r3_in;
    logic [ADDR_W-1:0] r3_addr;

    logic [SUMW-1:0]   n4_sum;
    logic              n4_hit;
    logic [DENS_W-1:0] n4_dens;

    logic              r_we;
    logic [ADDR_W-1:0] r_addr;
    logic [DENS_W-1:0] r_dens;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape_kind <= '0;
            r_center_x   <= '0;
            r_center_y   <= '0;
            r_center_z   <= '0;
            r_half_x     <= '0;
            r_half_y     <= '0;
            r_half_z     <= '0;
            r_density    <= '0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_SHAPE_KIND: r_shape_kind <= i_cfg_data[KIND_W-1:0];
                CFG_CENTER_X:   r_center_x   <= $signed(i_cfg_data[CENTER_W-1:0]);
                CFG_CENTER_Y:   r_center_y   <= $signed(i_cfg_data[CENTER_W-1:0]);
                CFG_CENTER_Z:   r_center_z   <= $signed(i_cfg_data[CENTER_W-1:0]);
                CFG_HALF_X:     r_half_x     <= i_cfg_data[HALF_W-1:0];
                CFG_HALF_Y:     r_half_y     <= i_cfg_data[HALF_W-1:0];
                CFG_HALF_Z:     r_half_z     <= i_cfg_data[HALF_W-1:0];
                CFG_DENSITY:    r_density    <= i_cfg_data[DENS_W-1:0];
            endcase
        end
    end

    assign ld4     = !r_v4 || i_ready;
    assign ld3     = !r_v3 || ld4;
    assign ld2     = !r_v2 || ld3;
    assign ld1     = !r_v1 || ld2;
    assign o_ready = ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
            if (ld4) begin
                r_v4 <= r_v3;
            end
        end
    end

    // Stage 1: offsets from the center and the bounding window.
    assign half_y_eff = (r_shape_kind == SHAPE_SPHERE) ? r_half_x : r_half_y;
    assign half_z_eff = (r_shape_kind == SHAPE_SPHERE) ? r_half_x : r_half_z;

    vpsf_axis #(.FRACTION_BITS(FRACTION_BITS), .GRID(GRID_X)) u_axis_x (
        .i_idx       (i_voxel_x),
        .i_center    (r_center_x),
        .i_half      (r_half_x),
        .o_mag       (n1_mag_x),
        .o_in_window (win_x)
    );

    vpsf_axis #(.FRACTION_BITS(FRACTION_BITS), .GRID(GRID_Y)) u_axis_y (
        .i_idx       (i_voxel_y),
        .i_center    (r_center_y),
        .i_half      (half_y_eff),
        .o_mag       (n1_mag_y),
        .o_in_window (win_y)
    );

    vpsf_axis #(.FRACTION_BITS(FRACTION_BITS), .GRID(GRID_Z)) u_axis_z (
        .i_idx       (i_voxel_z),
        .i_center    (r_center_z),
        .i_half      (half_z_eff),
        .o_mag       (n1_mag_z),
        .o_in_window (win_z)
    );

    assign n1_in = win_x && win_y && win_z && (r_shape_kind <= SHAPE_CYL_Z);
    assign n1_zx = ADDR_W'(i_voxel_z) * ADDR_W'(GRID_X) + ADDR_W'(i_voxel_x);

    always_ff @(posedge i_clk) begin
        if (ld1) begin
            r1_mag_x <= n1_mag_x;
            r1_mag_y <= n1_mag_y;
            r1_mag_z <= n1_mag_z;
            r1_in    <= n1_in;
            r1_zx    <= n1_zx;
            r1_y     <= i_voxel_y;
        end
    end

    // Stage 2: a cylinder's ellipse test is rescaled so only squares remain.
    always_comb begin
        sel_ma = '0;
        sel_mb = '0;
        sel_ha = '0;
        sel_hb = '0;
        unique case (t_shape_kind'(r_shape_kind))
            SHAPE_CYL_X: begin
                sel_ma = r1_mag_y;
                sel_mb = r1_mag_z;
                sel_ha = r_half_y;
                sel_hb = r_half_z;
            end
            SHAPE_CYL_Y: begin
                sel_ma = r1_mag_x;
                sel_mb = r1_mag_z;
                sel_ha = r_half_x;
                sel_hb = r_half_z;
            end
            SHAPE_CYL_Z: begin
                sel_ma = r1_mag_x;
                sel_mb = r1_mag_y;
                sel_ha = r_half_x;
                sel_hb = r_half_y;
            end
            default: begin
            end
        endcase
    end

    assign prod_a = UW'(sel_ma) * UW'(sel_hb);
    assign prod_b = UW'(sel_mb) * UW'(sel_ha);
    assign prod_h = TW'(sel_ha) * TW'(sel_hb);

    always_comb begin
        if (r_shape_kind == SHAPE_SPHERE) begin
            n2_u = UW'(r1_mag_x);
            n2_v = UW'(r1_mag_y);
            n2_w = r1_mag_z;
            n2_t = TW'(r_half_x);
        end else begin
            n2_u = prod_a;
            n2_v = prod_b;
            n2_w = '0;
            n2_t = prod_h;
        end
    end

    assign n2_addr = r1_zx * ADDR_W'(GRID_Y) + ADDR_W'(r1_y);

    always_ff @(posedge i_clk) begin
        if (ld2) begin
            r2_u    <= n2_u;
            r2_v    <= n2_v;
            r2_w    <= n2_w;
            r2_t    <= n2_t;
            r2_in   <= r1_in;
            r2_addr <= n2_addr;
        end
    end

    // Stage 3: squares.
    always_ff @(posedge i_clk) begin
        if (ld3) begin
            r3_su   <= (2*UW)'(r2_u) * (2*UW)'(r2_u);
            r3_sv   <= (2*UW)'(r2_v) * (2*UW)'(r2_v);
            r3_sw   <= (2*MW)'(r2_w) * (2*MW)'(r2_w);
            r3_st   <= (2*TW)'(r2_t) * (2*TW)'(r2_t);
            r3_in   <= r2_in;
            r3_addr <= r2_addr;
        end
    end

    // Stage 4: sum, compare and output register.
    assign n4_sum  = SUMW'(r3_su) + SUMW'(r3_sv) + SUMW'(r3_sw);
    assign n4_hit  = r3_in && ((r_shape_kind == SHAPE_BOX) || (n4_sum <= SUMW'(r3_st)));
    assign n4_dens = n4_hit ? r_density : '0;

    always_ff @(posedge i_clk) begin
        if (ld4) begin
            r_we   <= n4_hit;
            r_addr <= r3_addr;
            r_dens <= n4_dens;
        end
    end

    assign o_valid         = r_v4;
    assign o_write_enable  = r_we;
    assign o_voxel_address = r_addr;
    assign o_density_out   = r_dens;

    a_no_density_without_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_write_enable |-> o_density_out == '0)
        else $error("Density is driven on a transaction without a write.");

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_v1 && r_v2 && r_v3 && r_v4 && !i_ready)
        else $error("Input is stalled while the pipeline has a free stage.");

    a_last_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 && ld4 |=> o_valid)
        else $error("A voxel in the square stage was lost on its way out.");

    a_no_write_for_unknown_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_enable |-> r_shape_kind <= SHAPE_CYL_Z)
        else $error("A write was issued for an undefined shape code.");

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Voxel phantom shape fill testbench
// Streams voxel coordinates through the block under several shape settings
// and checks each write transaction against a predictor of the shape tests.
// Directed tests cover the reset state, every shape, window clamping,
// boundary voxels, zero extents and unused shape codes. Random phases follow.
// ----------------------------------------------------------------------------
module tb;

    import vpsf_pkg::*;

    localparam int GRID_X         = 256;
    localparam int GRID_Y         = 256;
    localparam int GRID_Z         = 256;
    localparam int FRAC_BITS      = 8;
    localparam int PIPE_LATENCY   = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_VOXELS  = 1500;
    localparam int STREAM_VOXELS  = 230;

    localparam logic [KIND_W-1:0] SHAPE_UNUSED_LO = 3'd5;
    localparam logic [KIND_W-1:0] SHAPE_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic              enable;
        logic [ADDR_W-1:0] addr;
        logic [DENS_W-1:0] dens;
    } t_fill_write;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_valid     = 1'b0;
    logic                  o_ready;
    logic [IDX_W-1:0]      i_voxel_x   = '0;
    logic [IDX_W-1:0]      i_voxel_y   = '0;
    logic [IDX_W-1:0]      i_voxel_z   = '0;
    logic                  o_valid;
    logic                  i_ready     = 1'b0;
    logic                  o_write_enable;
    logic [ADDR_W-1:0]     o_voxel_address;
    logic [DENS_W-1:0]     o_density_out;

    // Shape registers as the predictor sees them.
    logic [KIND_W-1:0]          shape_q   = SHAPE_SPHERE;
    logic signed [CENTER_W-1:0] cen_x_q   = '0;
    logic signed [CENTER_W-1:0] cen_y_q   = '0;
    logic signed [CENTER_W-1:0] cen_z_q   = '0;
    logic [HALF_W-1:0]          half_x_q  = '0;
    logic [HALF_W-1:0]          half_y_q  = '0;
    logic [HALF_W-1:0]          half_z_q  = '0;
    logic [DENS_W-1:0]          density_q = '0;

    t_fill_write pending_writes[$];
    int          mismatches     = 0;
    int          voxels_sent    = 0;
    int          writes_enabled = 0;
    int          writes_skipped = 0;
    int          shapes_loaded  = 0;
    bit          bursts_on      = 1'b1;

    voxel_phantom_shape_fill #(
        .GRID_X        (GRID_X),
        .GRID_Y        (GRID_Y),
        .GRID_Z        (GRID_Z),
        .FRACTION_BITS (FRAC_BITS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_voxel_x       (i_voxel_x),
        .i_voxel_y       (i_voxel_y),
        .i_voxel_z       (i_voxel_z),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_write_enable  (o_write_enable),
        .o_voxel_address (o_voxel_address),
        .o_density_out   (o_density_out)
    );

    always #4 i_clk = ~i_clk;

    function automatic bit in_axis_window(input logic [IDX_W-1:0] idx, input longint c,
                                          input longint h, input longint grid);
        longint lo;
        longint hi;
        lo = (c - h) >>> FRAC_BITS;
        hi = (c + h) >>> FRAC_BITS;
        if (lo < 0) begin
            lo = 0;
        end
        if (hi > grid) begin
            hi = grid;
        end
        return (longint'(idx) >= lo) && (longint'(idx) < hi);
    endfunction

    function automatic bit in_cross_ellipse(input longint da, input longint db,
                                            input longint ha, input longint hb);
        logic [127:0] da2;
        logic [127:0] db2;
        logic [127:0] ha2;
        logic [127:0] hb2;
        da2 = 128'(da * da);
        db2 = 128'(db * db);
        ha2 = 128'(ha * ha);
        hb2 = 128'(hb * hb);
        return (da2 * hb2 + db2 * ha2) <= (ha2 * hb2);
    endfunction

    function automatic t_fill_write predict_fill(input logic [IDX_W-1:0] vx,
                                                 input logic [IDX_W-1:0] vy,
                                                 input logic [IDX_W-1:0] vz);
        t_fill_write w;
        longint      cx;
        longint      cy;
        longint      cz;
        longint      hx;
        longint      hy;
        longint      hz;
        longint      dx;
        longint      dy;
        longint      dz;
        bit          hit;
        cx  = longint'(cen_x_q);
        cy  = longint'(cen_y_q);
        cz  = longint'(cen_z_q);
        hx  = longint'(half_x_q);
        hy  = longint'(half_y_q);
        hz  = longint'(half_z_q);
        dx  = (longint'(vx) <<< FRAC_BITS) - cx;
        dy  = (longint'(vy) <<< FRAC_BITS) - cy;
        dz  = (longint'(vz) <<< FRAC_BITS) - cz;
        hit = 1'b0;
        case (shape_q)
            SHAPE_SPHERE: begin
                if (in_axis_window(vx, cx, hx, GRID_X) && in_axis_window(vy, cy, hx, GRID_Y)
                        && in_axis_window(vz, cz, hx, GRID_Z)) begin
                    hit = (dx * dx + dy * dy + dz * dz) <= (hx * hx);
                end
            end
            SHAPE_BOX, SHAPE_CYL_X, SHAPE_CYL_Y, SHAPE_CYL_Z: begin
                if (in_axis_window(vx, cx, hx, GRID_X) && in_axis_window(vy, cy, hy, GRID_Y)
                        && in_axis_window(vz, cz, hz, GRID_Z)) begin
                    case (shape_q)
                        SHAPE_CYL_X: hit = in_cross_ellipse(dy, dz, hy, hz);
                        SHAPE_CYL_Y: hit = in_cross_ellipse(dx, dz, hx, hz);
                        SHAPE_CYL_Z: hit = in_cross_ellipse(dx, dy, hx, hy);
                        default:     hit = 1'b1;
                    endcase
                end
            end
            default: hit = 1'b0;
        endcase
        w.enable = hit;
        w.addr   = ADDR_W'((longint'(vz) * GRID_X + longint'(vx)) * GRID_Y + longint'(vy));
        w.dens   = hit ? density_q : '0;
        return w;
    endfunction

    // Receiver side: ready drops in random bursts while idling is enabled.
    initial begin : write_sink
        forever begin
            @(posedge i_clk);
            if (bursts_on && $urandom_range(0, 7) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_writes
        t_fill_write want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected write, expected none, got addr %h we %b dens %h",
                         $time, o_voxel_address, o_write_enable, o_density_out);
                mismatches++;
            end else begin
                want = pending_writes.pop_front();
                if (o_write_enable !== want.enable) begin
                    $display("%0t: write_enable expected %b, got %b (addr %h)",
                             $time, want.enable, o_write_enable, want.addr);
                    mismatches++;
                end
                if (o_voxel_address !== want.addr) begin
                    $display("%0t: voxel_address expected %h, got %h",
                             $time, want.addr, o_voxel_address);
                    mismatches++;
                end
                if (o_density_out !== want.dens) begin
                    $display("%0t: density_out expected %h, got %h (addr %h)",
                             $time, want.dens, o_density_out, want.addr);
                    mismatches++;
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no transaction for %0d cycles, %0d writes outstanding",
                 $time, WATCHDOG_LIMIT, pending_writes.size());
        $display("CHECK FAILED");
        $finish;
    end

    task automatic send_voxel(input logic [IDX_W-1:0] vx, input logic [IDX_W-1:0] vy,
                              input logic [IDX_W-1:0] vz);
        if (bursts_on && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_voxel_x <= vx;
        i_voxel_y <= vy;
        i_voxel_z <= vz;
        do @(posedge i_clk); while (!o_ready);
        pending_writes.push_back(predict_fill(vx, vy, vz));
        if (pending_writes[$].enable) begin
            writes_enabled++;
        end else begin
            writes_skipped++;
        end
        voxels_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (pending_writes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_SHAPE_KIND: shape_q   = data[KIND_W-1:0];
            CFG_CENTER_X:   cen_x_q   = data;
            CFG_CENTER_Y:   cen_y_q   = data;
            CFG_CENTER_Z:   cen_z_q   = data;
            CFG_HALF_X:     half_x_q  = data[HALF_W-1:0];
            CFG_HALF_Y:     half_y_q  = data[HALF_W-1:0];
            CFG_HALF_Z:     half_z_q  = data[HALF_W-1:0];
            CFG_DENSITY:    density_q = data[DENS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_shape(input logic [KIND_W-1:0] kind,
                              input logic [CFG_DATA_W-1:0] cx, input logic [CFG_DATA_W-1:0] cy,
                              input logic [CFG_DATA_W-1:0] cz, input logic [HALF_W-1:0] hx,
                              input logic [HALF_W-1:0] hy, input logic [HALF_W-1:0] hz,
                              input logic [DENS_W-1:0] dens);
        wait_drained();
        write_reg(CFG_SHAPE_KIND, CFG_DATA_W'(kind));
        write_reg(CFG_CENTER_X, cx);
        write_reg(CFG_CENTER_Y, cy);
        write_reg(CFG_CENTER_Z, cz);
        write_reg(CFG_HALF_X, CFG_DATA_W'(hx));
        write_reg(CFG_HALF_Y, CFG_DATA_W'(hy));
        write_reg(CFG_HALF_Z, CFG_DATA_W'(hz));
        write_reg(CFG_DENSITY, CFG_DATA_W'(dens));
        i_cfg_valid <= 1'b0;
        shapes_loaded++;
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_center();
        int v;
        case ($urandom_range(0, 11))
            0:       v = -65536;
            1:       v = 131071;
            2:       v = int'($urandom_range(0, 196607)) - 65536;
            default: v = int'($urandom_range(0, 65535));
        endcase
        return CFG_DATA_W'(v);
    endfunction

    function automatic logic [HALF_W-1:0] pick_half();
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2:       return HALF_W'($urandom_range(0, 65535));
            default: return HALF_W'($urandom_range(0, 24 << FRAC_BITS));
        endcase
    endfunction

    // Mostly coordinates around the shape so that both sides of its surface are hit.
    function automatic logic [IDX_W-1:0] pick_index(input logic [CFG_DATA_W-1:0] c,
                                                    input logic [HALF_W-1:0] h);
        int base;
        int span;
        int v;
        if ($urandom_range(0, 3) == 0) begin
            return IDX_W'($urandom_range(0, 255));
        end
        base = int'($signed(c)) >>> FRAC_BITS;
        span = int'(h >> FRAC_BITS) + 2;
        v    = base - span + int'($urandom_range(0, 2 * span));
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return IDX_W'(v);
    endfunction

    task automatic run_random_phases(input int total, input bit with_bursts);
        logic [KIND_W-1:0]     kind;
        logic [CFG_DATA_W-1:0] cx;
        logic [CFG_DATA_W-1:0] cy;
        logic [CFG_DATA_W-1:0] cz;
        logic [HALF_W-1:0]     hx;
        logic [HALF_W-1:0]     hy;
        logic [HALF_W-1:0]     hz;
        logic [HALF_W-1:0]     span_y;
        logic [HALF_W-1:0]     span_z;
        int                    sent;
        int                    phase_len;
        sent = 0;
        while (sent < total) begin
            kind = ($urandom_range(0, 9) == 0) ? KIND_W'($urandom_range(5, 7))
                                               : KIND_W'($urandom_range(0, 4));
            cx   = pick_center();
            cy   = pick_center();
            cz   = pick_center();
            hx   = pick_half();
            hy   = pick_half();
            hz   = pick_half();
            load_shape(kind, cx, cy, cz, hx, hy, hz, DENS_W'($urandom_range(0, 65535)));
            bursts_on = with_bursts && ($urandom_range(0, 3) != 0);
            span_y    = (kind == SHAPE_SPHERE) ? hx : hy;
            span_z    = (kind == SHAPE_SPHERE) ? hx : hz;
            phase_len = $urandom_range(40, 100);
            for (int k = 0; k < phase_len && sent < total; k++) begin
                send_voxel(pick_index(cx, hx), pick_index(cy, span_y), pick_index(cz, span_z));
                sent++;
            end
        end
    endtask

    // After reset the registers describe a zero-radius sphere.
    task automatic test_reset_state();
        send_voxel(8'd0, 8'd0, 8'd0);
        send_voxel(8'd255, 8'd255, 8'd255);
    endtask

    // Radius 4 around voxel 8; the upper window edge excludes a voxel on the surface.
    task automatic test_sphere();
        load_shape(SHAPE_SPHERE, 18'd2048, 18'd2048, 18'd2048, 16'd1024, 16'd0, 16'd0, '1);
        send_voxel(8'd8, 8'd8, 8'd8);
        send_voxel(8'd12, 8'd8, 8'd8);
        send_voxel(8'd4, 8'd8, 8'd8);
        send_voxel(8'd11, 8'd11, 8'd8);
    endtask

    // The x window is clamped at both grid edges, y at zero only.
    task automatic test_box();
        load_shape(SHAPE_BOX, 18'd32768, 18'd0, 18'd25728, 16'hFFFF, 16'd256, 16'd384, 16'd1);
        send_voxel(8'd0, 8'd0, 8'd99);
        send_voxel(8'd255, 8'd0, 8'd101);
        send_voxel(8'd255, 8'd1, 8'd100);
        send_voxel(8'd0, 8'd0, 8'd102);
        send_voxel(8'd0, 8'd0, 8'd98);
    endtask

    task automatic test_cylinders();
        load_shape(SHAPE_CYL_X, 18'd4096, 18'd4096, 18'd4096,
                   16'd2048, 16'd512, 16'd1536, 16'h00A5);
        send_voxel(8'd16, 8'd14, 8'd16);
        send_voxel(8'd12, 8'd16, 8'd22);
        load_shape(SHAPE_CYL_Y, 18'd4096, 18'd4096, 18'd4096,
                   16'd768, 16'd1280, 16'd512, 16'h5A00);
        send_voxel(8'd16, 8'd16, 8'd16);
        send_voxel(8'd19, 8'd20, 8'd16);
        load_shape(SHAPE_CYL_Z, 18'd4096, 18'd4096, 18'd4096,
                   16'd1024, 16'd1024, 16'd2048, 16'h8001);
        send_voxel(8'd16, 8'd16, 8'd16);
        send_voxel(8'd13, 8'd13, 8'd16);
    endtask

    task automatic test_zero_extent();
        load_shape(SHAPE_BOX, 18'd12800, 18'd12800, 18'd12800, 16'd2560, 16'd0, 16'd2560, '1);
        send_voxel(8'd50, 8'd50, 8'd50);
        load_shape(SHAPE_CYL_Z, 18'd12800, 18'd12800, 18'd12800, 16'd2560, 16'd2560, 16'd0, '1);
        send_voxel(8'd50, 8'd50, 8'd50);
    endtask

    task automatic test_unused_codes();
        load_shape(SHAPE_UNUSED_LO, 18'd32768, 18'd32768, 18'd32768, '1, '1, '1, '1);
        send_voxel(8'd128, 8'd128, 8'd128);
        load_shape(SHAPE_UNUSED_HI, 18'd32768, 18'd32768, 18'd32768, '1, '1, '1, '1);
        send_voxel(8'd128, 8'd128, 8'd128);
    endtask

    task automatic test_random_shapes();
        run_random_phases(RANDOM_VOXELS, 1'b1);
    endtask

    // Back-to-back traffic on both channels with no random idling.
    task automatic test_full_rate();
        wait_drained();
        bursts_on = 1'b0;
        run_random_phases(STREAM_VOXELS, 1'b0);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_sphere();
        test_box();
        test_cylinders();
        test_zero_extent();
        test_unused_codes();
        test_random_shapes();
        test_full_rate();
        wait_drained();
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        $display("Covered %0d voxels over %0d shape settings, every shape and unused codes.",
                 voxels_sent, shapes_loaded);
        $display("Predicted %0d enabled and %0d disabled writes, %0d mismatches.",
                 writes_enabled, writes_skipped, mismatches);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
